@@ src/ptqls_pkg.sv @@
// ----------------------------------------------------------------------------
// ptqls_pkg: shared types for the per-type queue latency statistics block
// Field widths, state encoding, mark codes and the command/status structs
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptqls_pkg;

  // Fixed field widths of the channels
  localparam int TYPE_W = 3;
  localparam int TS_W   = 32;
  localparam int STAT_W = 32;

  // Largest sample count; the count sticks here
  localparam logic [STAT_W-1:0] COUNT_MAX = '1;

  // Mark codes
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } ptqls_mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_DONE
  } ptqls_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming beat
    logic look;      // read the entry and register the update plan
    logic div_load;  // start the mean divider
    logic div_step;  // one quotient bit
    logic commit;    // write the entry back and load the result register
  } ptqls_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic do_div;    // this mark needs a mean division
    logic div_last;  // divider is on its final bit
    logic out_free;  // result register can take a new beat
  } ptqls_sts_t;

endpackage

`default_nettype wire

@@ src/ptqls_ifs.sv @@
// ----------------------------------------------------------------------------
// ptqls channel interfaces
// Valid/ready channels for queue marks (input) and statistics results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptqls_in_if
  import ptqls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] event_type;
  logic              mode;
  logic [TS_W-1:0]   timestamp_ms;

  modport source (output valid, event_type, mode, timestamp_ms, input ready);
  modport sink   (input valid, event_type, mode, timestamp_ms, output ready);
endinterface

interface ptqls_out_if
  import ptqls_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              measured;
  logic [STAT_W-1:0] latency_ms;
  logic [STAT_W-1:0] max_latency_ms;
  logic [STAT_W-1:0] mean_latency_ms;
  logic [STAT_W-1:0] sample_count;

  modport source (output valid, accepted, measured, latency_ms, max_latency_ms,
                  mean_latency_ms, sample_count, input ready);
  modport sink   (input valid, accepted, measured, latency_ms, max_latency_ms,
                  mean_latency_ms, sample_count, output ready);
endinterface

`default_nettype wire

@@ src/ptqls_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptqls_ctrl: sequencing state machine
// Takes one mark at a time: capture, table lookup, optional mean division,
// then write-back together with the load of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqls_ctrl
  import ptqls_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  ptqls_sts_t  sts,
  output ptqls_cmd_t  cmd
);

  ptqls_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = sts.do_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOK: begin
        cmd.look     = 1'b1;
        cmd.div_load = sts.do_div;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ptqls_dp.sv @@
// ----------------------------------------------------------------------------
// ptqls_dp: statistics table, latency arithmetic and mean divider
// Holds the per-type entries in flops, plans the update of one entry,
// divides the mean step by the sample count one bit per cycle and drives
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqls_dp
  import ptqls_pkg::*;
#(
  parameter int NUM_TYPES  = 8,
  parameter int TIME_WIDTH = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  ptqls_cmd_t        cmd,
  output ptqls_sts_t        sts,
  // captured mark
  input  wire [TYPE_W-1:0]  in_event_type,
  input  wire               in_mode,
  input  wire [TS_W-1:0]    in_timestamp_ms,
  // result register
  input  wire               out_ready,
  output logic              out_valid,
  output logic              out_accepted,
  output logic              out_measured,
  output logic [STAT_W-1:0] out_latency_ms,
  output logic [STAT_W-1:0] out_max_latency_ms,
  output logic [STAT_W-1:0] out_mean_latency_ms,
  output logic [STAT_W-1:0] out_sample_count
);

  // Only types reachable by the 3-bit index get an entry
  localparam int MAX_IDX = 2 ** TYPE_W;
  localparam int DEPTH   = (NUM_TYPES < MAX_IDX) ? NUM_TYPES : MAX_IDX;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REM_W   = ((TIME_WIDTH > STAT_W) ? TIME_WIDTH : STAT_W) + 1;
  localparam int STEP_W  = $clog2(TIME_WIDTH);

  // Captured mark
  logic [TYPE_W-1:0]     cap_type_r;
  logic                  cap_mode_r;
  logic [TIME_WIDTH-1:0] cap_now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_type_r <= in_event_type;
      cap_mode_r <= in_mode;
      cap_now_r  <= TIME_WIDTH'(in_timestamp_ms);
    end
  end

  // Per-type table
  logic                  pend_r [DEPTH];
  logic [TIME_WIDTH-1:0] enq_r  [DEPTH];
  logic [TIME_WIDTH-1:0] max_r  [DEPTH];
  logic [TIME_WIDTH-1:0] mean_r [DEPTH];
  logic [STAT_W-1:0]     cnt_r  [DEPTH];

  logic [IDX_W-1:0] idx;
  assign idx = cap_type_r[IDX_W-1:0];

  // Lookup and update plan
  logic                  vt, is_deq, enq_ok, deq_ok, ge;
  logic                  e_pend;
  logic [TIME_WIDTH-1:0] e_enq, e_max, e_mean, lat, mag;
  logic [STAT_W-1:0]     e_cnt, cnt_inc;

  always_comb begin
    vt      = 32'(cap_type_r) < 32'(NUM_TYPES);
    e_pend  = pend_r[idx];
    e_enq   = enq_r[idx];
    e_max   = max_r[idx];
    e_mean  = mean_r[idx];
    e_cnt   = cnt_r[idx];
    is_deq  = (cap_mode_r == MODE_DEQ);
    enq_ok  = vt && !is_deq && !e_pend;
    deq_ok  = vt && is_deq && e_pend;
    lat     = cap_now_r - e_enq;
    cnt_inc = (e_cnt == COUNT_MAX) ? e_cnt : e_cnt + 1'b1;
    ge      = (lat >= e_mean);
    mag     = ge ? (lat - e_mean) : (e_mean - lat);
  end

  assign sts.do_div = deq_ok && (cnt_inc > STAT_W'(1));

  logic                  lk_vt_r, lk_acc_r, lk_meas_r, lk_ge_r, lk_div_r, lk_pend_r;
  logic [TIME_WIDTH-1:0] lk_lat_r, lk_max_r, lk_mean_r, lk_enq_r;
  logic [STAT_W-1:0]     lk_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      lk_vt_r   <= vt;
      lk_acc_r  <= enq_ok || deq_ok;
      lk_meas_r <= deq_ok;
      lk_lat_r  <= deq_ok ? lat : '0;
      lk_max_r  <= (deq_ok && (lat > e_max)) ? lat : e_max;
      lk_cnt_r  <= deq_ok ? cnt_inc : e_cnt;
      lk_mean_r <= e_mean;
      lk_ge_r   <= ge;
      lk_div_r  <= sts.do_div;
      lk_pend_r <= enq_ok ? 1'b1 : (deq_ok ? 1'b0 : e_pend);
      lk_enq_r  <= enq_ok ? cap_now_r : (deq_ok ? '0 : e_enq);
    end
  end

  // Restoring divider: |latency - mean| / count, one quotient bit a cycle
  logic [TIME_WIDTH-1:0] q_r;
  logic [REM_W-1:0]      rem_r, rem_sh, dsr;
  logic [STEP_W-1:0]     step_r;
  logic                  fits;

  assign rem_sh = {rem_r[REM_W-2:0], q_r[TIME_WIDTH-1]};
  assign dsr    = REM_W'(lk_cnt_r);
  assign fits   = (rem_sh >= dsr);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r    <= mag;
      rem_r  <= '0;
      step_r <= STEP_W'(TIME_WIDTH - 1);
    end else if (cmd.div_step) begin
      rem_r  <= fits ? (rem_sh - dsr) : rem_sh;
      q_r    <= {q_r[TIME_WIDTH-2:0], fits};
      step_r <= step_r - 1'b1;
    end
  end

  assign sts.div_last = (step_r == '0);

  // New mean: first sample sets it, later ones step toward the latency
  logic [TIME_WIDTH-1:0] mean_new;

  always_comb begin
    if (lk_div_r) begin
      mean_new = lk_ge_r ? (lk_mean_r + q_r) : (lk_mean_r - q_r);
    end else if (lk_meas_r) begin
      mean_new = lk_lat_r;
    end else begin
      mean_new = lk_mean_r;
    end
  end

  // Table write-back; reset clears every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        pend_r[i] <= 1'b0;
        enq_r[i]  <= '0;
        max_r[i]  <= '0;
        mean_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.commit && lk_vt_r) begin
      pend_r[idx] <= lk_pend_r;
      enq_r[idx]  <= lk_enq_r;
      max_r[idx]  <= lk_max_r;
      mean_r[idx] <= mean_new;
      cnt_r[idx]  <= lk_cnt_r;
    end
  end

  // Result register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // An unknown type reports all zeros
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_accepted        <= lk_vt_r && lk_acc_r;
      out_measured        <= lk_vt_r && lk_meas_r;
      out_latency_ms      <= lk_vt_r ? STAT_W'(lk_lat_r) : '0;
      out_max_latency_ms  <= lk_vt_r ? STAT_W'(lk_max_r) : '0;
      out_mean_latency_ms <= lk_vt_r ? STAT_W'(mean_new) : '0;
      out_sample_count    <= lk_vt_r ? lk_cnt_r : '0;
    end
  end

endmodule

`default_nettype wire

@@ src/per_type_queue_latency_stats.sv @@
// ----------------------------------------------------------------------------
// per_type_queue_latency_stats: per-type queue latency max / mean / count
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------
//   in_ch   | in  | event_type, mode (enqueue/dequeue), timestamp_ms
//   out_ch  | out | accepted, measured, latency_ms, max_latency_ms,
//           |     | mean_latency_ms, sample_count
//
// One mark at a time: after accept come the table lookup, the mean division when
// needed and the write-back with the load of the result register; only then can
// the next mark be accepted. A dequeue that updates an existing mean runs the
// bit-serial mean divider, which produces TIME_WIDTH quotient bits.
// Reset (rst_n, synchronous) clears the whole table.
// A stalled result sits in the output register; the next mark is accepted
// meanwhile and waits at write-back until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module per_type_queue_latency_stats
  import ptqls_pkg::*;
#(
  parameter int NUM_TYPES  = 8,
  parameter int TIME_WIDTH = 32
) (
  input  wire           clk,
  input  wire           rst_n,
  ptqls_in_if.sink      in_ch,
  ptqls_out_if.source   out_ch
);

  ptqls_cmd_t cmd;
  ptqls_sts_t sts;

  // Sequencer
  ptqls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, arithmetic and result register
  ptqls_dp #(
    .NUM_TYPES  (NUM_TYPES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_event_type       (in_ch.event_type),
    .in_mode             (in_ch.mode),
    .in_timestamp_ms     (in_ch.timestamp_ms),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_accepted        (out_ch.accepted),
    .out_measured        (out_ch.measured),
    .out_latency_ms      (out_ch.latency_ms),
    .out_max_latency_ms  (out_ch.max_latency_ms),
    .out_mean_latency_ms (out_ch.mean_latency_ms),
    .out_sample_count    (out_ch.sample_count)
  );

endmodule

`default_nettype wire

@@ src/ptqls_checker.sv @@
// ----------------------------------------------------------------------------
// ptqls_checker: port-level checks for the latency statistics block
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ptqls_checker
  import ptqls_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_valid,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire              out_accepted,
  input wire              out_measured,
  input wire [STAT_W-1:0] out_latency_ms,
  input wire [STAT_W-1:0] out_max_latency_ms,
  input wire [STAT_W-1:0] out_mean_latency_ms,
  input wire [STAT_W-1:0] out_sample_count
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_latency_ms)
      && $stable(out_mean_latency_ms) && $stable(out_sample_count))
    else $error("result beat changed while stalled");

  // One mark in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("mark accepted while previous one in flight");

  // A measurement is always an accepted mark
  a_meas_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measured |-> out_accepted && (out_sample_count != '0))
    else $error("measurement without accept or count");

  // No measurement, no latency
  a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_measured |-> out_latency_ms == '0)
    else $error("latency reported without measurement");

  // First sample sets mean and max
  a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measured && (out_sample_count == STAT_W'(1))
      |-> (out_mean_latency_ms == out_latency_ms)
        && (out_max_latency_ms == out_latency_ms))
    else $error("first sample did not set mean and max");

endmodule

bind per_type_queue_latency_stats ptqls_checker u_ptqls_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_accepted        (out_ch.accepted),
  .out_measured        (out_ch.measured),
  .out_latency_ms      (out_ch.latency_ms),
  .out_max_latency_ms  (out_ch.max_latency_ms),
  .out_mean_latency_ms (out_ch.mean_latency_ms),
  .out_sample_count    (out_ch.sample_count)
);

`default_nettype wire

@@ sim/per_type_queue_latency_stats_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_type_queue_latency_stats_tb: regression for the queue latency stats block
// Drives enqueue/dequeue marks, keeps a per-type latency table of its own and
// checks every result beat field by field. It covers directed corner marks,
// random mark streams under several idle mixes, a long result hold-off and a
// sender pause until all results are back.
// ----------------------------------------------------------------------------

module per_type_queue_latency_stats_tb;
  import ptqls_pkg::*;

  localparam int NUM_TYPES   = 8;
  localparam int TIME_WIDTH  = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_PRINTS  = 40;

  // One expected result beat
  typedef struct packed {
    logic              accepted;
    logic              measured;
    logic [STAT_W-1:0] latency_ms;
    logic [STAT_W-1:0] max_latency_ms;
    logic [STAT_W-1:0] mean_latency_ms;
    logic [STAT_W-1:0] sample_count;
  } stat_beat_t;

  logic clk;
  logic rst_n;

  ptqls_in_if  mark_ch ();
  ptqls_out_if stat_ch ();

  per_type_queue_latency_stats #(
    .NUM_TYPES (NUM_TYPES),
    .TIME_WIDTH(TIME_WIDTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (mark_ch),
    .out_ch(stat_ch)
  );

  // Local copy of the per-type latency table
  logic              mark_pending [NUM_TYPES];
  logic [TS_W-1:0]   enq_stamp    [NUM_TYPES];
  logic [STAT_W-1:0] lat_max      [NUM_TYPES];
  logic [STAT_W-1:0] lat_mean     [NUM_TYPES];
  logic [STAT_W-1:0] lat_count    [NUM_TYPES];

  stat_beat_t stats_due [$];

  int error_count    = 0;
  int marks_sent     = 0;
  int samples_taken  = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_req   = 0;
  int hold_left      = 0;

  // Clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               stats_due.size());
      $display("per_type_queue_latency_stats regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("MISMATCH cycle %0d result %0d %s: got 0x%08h want 0x%08h",
               cycle_count, results_seen, what, got, want);
  endtask

  // Apply one mark to the local table and return the beat it should produce
  function automatic stat_beat_t update_latency_table(input logic [TYPE_W-1:0] ty,
                                                      input ptqls_mode_t md,
                                                      input logic [TS_W-1:0] ts);
    stat_beat_t      r;
    logic [TS_W-1:0] lat;
    r   = '0;
    lat = '0;
    if (md == MODE_ENQ) begin
      if (!mark_pending[ty]) begin
        enq_stamp[ty]    = ts;
        mark_pending[ty] = 1'b1;
        r.accepted       = 1'b1;
      end
    end else if (mark_pending[ty]) begin
      lat              = ts - enq_stamp[ty];
      enq_stamp[ty]    = '0;
      mark_pending[ty] = 1'b0;
      if (lat > lat_max[ty]) lat_max[ty] = lat;
      if (lat_count[ty] != COUNT_MAX) lat_count[ty] = lat_count[ty] + 1'b1;
      // running mean, sign/magnitude so it never overshoots the sample
      if (lat_count[ty] > 1) begin
        if (lat >= lat_mean[ty])
          lat_mean[ty] = lat_mean[ty] + (lat - lat_mean[ty]) / lat_count[ty];
        else
          lat_mean[ty] = lat_mean[ty] - (lat_mean[ty] - lat) / lat_count[ty];
      end else begin
        lat_mean[ty] = lat;
      end
      r.accepted = 1'b1;
      r.measured = 1'b1;
      samples_taken++;
    end
    r.latency_ms      = lat;
    r.max_latency_ms  = lat_max[ty];
    r.mean_latency_ms = lat_mean[ty];
    r.sample_count    = lat_count[ty];
    return r;
  endfunction

  // Send one mark beat, with optional idle cycles in front of it
  task automatic send_mark(input logic [TYPE_W-1:0] ty, input ptqls_mode_t md,
                           input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      mark_ch.valid        <= 1'b0;
      mark_ch.event_type   <= TYPE_W'($urandom);
      mark_ch.mode         <= 1'($urandom);
      mark_ch.timestamp_ms <= $urandom;
      @(posedge clk);
    end
    mark_ch.valid        <= 1'b1;
    mark_ch.event_type   <= ty;
    mark_ch.mode         <= md;
    mark_ch.timestamp_ms <= ts;
    do @(posedge clk); while (!mark_ch.ready);
    stats_due.push_back(update_latency_table(ty, md, ts));
    marks_sent++;
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic wait_results_drained();
    mark_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
  endtask

  // Random marks, mostly well-formed enqueue/dequeue pairs; n_marks counts
  // every mark sent, ignored ones included
  task automatic random_marks(input int n_marks);
    int                done;
    int                roll;
    logic [TYPE_W-1:0] ty;
    ptqls_mode_t       md;
    logic [TS_W-1:0]   ts;
    logic [TS_W-1:0]   lat;
    done = 0;
    while (done < n_marks) begin
      ty   = TYPE_W'($urandom_range(NUM_TYPES - 1));
      roll = $urandom_range(99);
      if (mark_pending[ty]) md = (roll < 88) ? MODE_DEQ : MODE_ENQ;
      else                  md = (roll < 88) ? MODE_ENQ : MODE_DEQ;
      // latency mix: mostly short, some long, a few near full range
      roll = $urandom_range(99);
      if (roll < 50)      lat = $urandom_range(200);
      else if (roll < 85) lat = $urandom_range(1 << 20);
      else if (roll < 95) lat = $urandom;
      else                lat = 32'hFFFF_FFFF - $urandom_range(3);
      ts = (md == MODE_DEQ) ? enq_stamp[ty] + lat : $urandom;
      done++;
      send_mark(ty, md, ts);
    end
  endtask

  // Receiver ready, with random stalls and a counted hold-off
  initial begin
    stat_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stat_ch.ready <= 1'b0;
      end else begin
        stat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    stat_beat_t want;
    if (rst_n && stat_ch.valid && stat_ch.ready) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        report_mismatch("unexpected beat, sample_count", stat_ch.sample_count, '0);
      end else begin
        want = stats_due.pop_front();
        if (stat_ch.accepted !== want.accepted)
          report_mismatch("accepted", 32'(stat_ch.accepted), 32'(want.accepted));
        if (stat_ch.measured !== want.measured)
          report_mismatch("measured", 32'(stat_ch.measured), 32'(want.measured));
        if (stat_ch.latency_ms !== want.latency_ms)
          report_mismatch("latency_ms", stat_ch.latency_ms, want.latency_ms);
        if (stat_ch.max_latency_ms !== want.max_latency_ms)
          report_mismatch("max_latency_ms", stat_ch.max_latency_ms, want.max_latency_ms);
        if (stat_ch.mean_latency_ms !== want.mean_latency_ms)
          report_mismatch("mean_latency_ms", stat_ch.mean_latency_ms,
                          want.mean_latency_ms);
        if (stat_ch.sample_count !== want.sample_count)
          report_mismatch("sample_count", stat_ch.sample_count, want.sample_count);
      end
    end
  end

  // Corner marks: extreme stamps, ignored marks, wrap, mean moving both ways
  task automatic test_directed_marks();
    int t;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_mark(3'd0, MODE_ENQ, 32'h0000_0000);
    send_mark(3'd0, MODE_ENQ, 32'h0000_0005);   // already pending: ignored
    send_mark(3'd0, MODE_DEQ, 32'hFFFF_FFFF);   // full-range latency
    send_mark(3'd0, MODE_DEQ, 32'h0000_0003);   // nothing pending: ignored
    send_mark(3'd0, MODE_ENQ, 32'h0000_0064);
    send_mark(3'd0, MODE_DEQ, 32'h0000_0064);   // zero latency, mean drops
    send_mark(3'd0, MODE_ENQ, 32'hFFFF_FFF0);
    send_mark(3'd0, MODE_DEQ, 32'h0000_0010);   // stamp wraps
    send_mark(3'd1, MODE_DEQ, 32'h0000_0000);   // untouched type
    send_mark(3'd7, MODE_ENQ, 32'h7FFF_FFFF);
    send_mark(3'd7, MODE_DEQ, 32'h8000_0009);
    send_mark(3'd7, MODE_ENQ, 32'h0000_0000);
    send_mark(3'd7, MODE_DEQ, 32'h0000_0028);   // mean rises
    for (t = 2; t < 7; t++) begin
      send_mark(t[TYPE_W-1:0], MODE_ENQ, 32'hAAAA_AAAA ^ t);
      send_mark(t[TYPE_W-1:0], MODE_DEQ, 32'h5555_5555 ^ t);
    end
    wait_results_drained();
  endtask

  task automatic test_random_phase(input int n_marks, input int idle_pct,
                                   input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    random_marks(n_marks);
    wait_results_drained();
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_result_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 400;
    random_marks(30);
    wait_results_drained();
  endtask

  // Sender stops mid-stream until every result is back, then resumes
  task automatic test_drain_pause();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    random_marks(20);
    wait_results_drained();
    random_marks(20);
    wait_results_drained();
  endtask

  // Test sequence
  initial begin
    mark_pending         = '{default: '0};
    enq_stamp            = '{default: '0};
    lat_max              = '{default: '0};
    lat_mean             = '{default: '0};
    lat_count            = '{default: '0};
    rst_n                <= 1'b0;
    mark_ch.valid        <= 1'b0;
    mark_ch.event_type   <= '0;
    mark_ch.mode         <= MODE_ENQ;
    mark_ch.timestamp_ms <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_marks();
    test_random_phase(470, 0, 0);
    test_random_phase(460, 68, 0);
    test_random_phase(460, 0, 68);
    test_random_phase(460, 8, 8);
    test_result_hold_off();
    test_drain_pause();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stats_due.size() != 0)
      report_mismatch("beats never returned", stats_due.size(), 0);

    $display("covered %0d marks and %0d latency samples over %0d checked beats,",
             marks_sent, samples_taken, results_seen);
    $display("with four idle/stall mixes, a long result hold-off and a drain pause");
    if (error_count == 0) begin
      $display("per_type_queue_latency_stats regression: pass");
    end else begin
      $display("per_type_queue_latency_stats regression: fail");
    end
    $finish;
  end

endmodule
